// ===== hdl/domain_name_validator_top_assert.svh =====
// Assertion macros shared by the validator modules.
`ifndef DOMAIN_NAME_VALIDATOR_TOP_ASSERT_SVH
`define DOMAIN_NAME_VALIDATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk_i, off during reset.
`define DNV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off during reset.
`define DNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DNV_ASSERT_SAME(lbl, ante, cons, msg)
`define DNV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/dnv_pkg.sv =====
package dnv_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_TOO_LONG    = 3'd2,
    ST_LABEL_SHORT = 3'd3,
    ST_LABEL_LONG  = 3'd4,
    ST_HYPHEN_EDGE = 3'd5,
    ST_BAD_CHAR    = 3'd6,
    ST_NUMERIC_TOP = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    LERR_NONE   = 2'd0,
    LERR_SHORT  = 2'd1,
    LERR_LONG   = 2'd2,
    LERR_HYPHEN = 2'd3
  } label_err_e;

  typedef enum logic [1:0] {
    REG_MAX_NAME   = 2'd0,
    REG_MIN_LABEL  = 2'd1,
    REG_MAX_LABEL  = 2'd2,
    REG_STRICT_TOP = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] max_name_length;
    logic [5:0] min_label_length;
    logic [5:0] max_label_length;
    logic       strict_top_label;
  } cfg_t;

  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  localparam logic [7:0] LABEL_CNT_SAT = 8'hFF;

  localparam logic [7:0]  RST_MAX_NAME   = 8'd253;
  localparam logic [5:0]  RST_MIN_LABEL  = 6'd1;
  localparam logic [5:0]  RST_MAX_LABEL  = 6'd63;
  localparam logic        RST_STRICT_TOP = 1'b1;

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_allowed(input logic [7:0] c);
    return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || is_numeral(c) ||
           (c == CH_HYPHEN) || (c == CH_DOT);
  endfunction

  // Check a label that has just closed.
  function automatic label_err_e label_err(input logic [7:0] cnt,
                                           input logic       starts_hy,
                                           input logic       prev_hy,
                                           input logic [5:0] min_len,
                                           input logic [5:0] max_len);
    label_err_e e;
    e = LERR_NONE;
    if (cnt < {2'b00, min_len}) begin
      e = LERR_SHORT;
    end else if (cnt > {2'b00, max_len}) begin
      e = LERR_LONG;
    end else if ((cnt != 8'd0) && (starts_hy || prev_hy)) begin
      e = LERR_HYPHEN;
    end
    return e;
  endfunction

endpackage

// ===== hdl/dnv_cfg.sv =====
module dnv_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output dnv_pkg::cfg_t      cfg_o
);

  dnv_pkg::cfg_t     cfg_q;
  dnv_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = dnv_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_name_length  <= dnv_pkg::RST_MAX_NAME;
      cfg_q.min_label_length <= dnv_pkg::RST_MIN_LABEL;
      cfg_q.max_label_length <= dnv_pkg::RST_MAX_LABEL;
      cfg_q.strict_top_label <= dnv_pkg::RST_STRICT_TOP;
    end else if (wr_en) begin
      case (idx)
        dnv_pkg::REG_MAX_NAME:   cfg_q.max_name_length  <= pwdata[7:0];
        dnv_pkg::REG_MIN_LABEL:  cfg_q.min_label_length <= pwdata[5:0];
        dnv_pkg::REG_MAX_LABEL:  cfg_q.max_label_length <= pwdata[5:0];
        dnv_pkg::REG_STRICT_TOP: cfg_q.strict_top_label <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dnv_pkg::REG_MAX_NAME:   prdata = {24'd0, cfg_q.max_name_length};
      dnv_pkg::REG_MIN_LABEL:  prdata = {26'd0, cfg_q.min_label_length};
      dnv_pkg::REG_MAX_LABEL:  prdata = {26'd0, cfg_q.max_label_length};
      dnv_pkg::REG_STRICT_TOP: prdata = {31'd0, cfg_q.strict_top_label};
      default:                 prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/dnv_scan.sv =====
`include "domain_name_validator_top_assert.svh"

module dnv_scan #(
  parameter int MAX_NAME_BYTES = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         char_byte_i,
  input  logic               has_char_i,
  input  logic               last_item_i,
  input  dnv_pkg::cfg_t      cfg_i,
  output dnv_pkg::status_e   code_o
);

  localparam int TW = $clog2(MAX_NAME_BYTES + 2);
  localparam int CW = (TW > 8) ? TW : 8;
  localparam logic [TW-1:0] TOT_SAT = TW'(MAX_NAME_BYTES + 1);
  localparam logic [CW-1:0] MAX_BYTES_C = CW'(MAX_NAME_BYTES);

  logic [TW-1:0]        tot_q, tot_d, tot_a;
  logic [7:0]           lc_q, lc_d, lc_a;
  logic                 bad_q, bad_d, bad_a;
  dnv_pkg::label_err_e  ferr_q, ferr_d, ferr_a, ferr_b, e_dot, e_end;
  logic                 sh_q, sh_d, sh_a;
  logic                 ph_q, ph_d, ph_a;
  logic                 dig_q, dig_d, dig_a;
  logic [CW-1:0]        tot_w;

  always_comb begin
    tot_a  = tot_q;
    lc_a   = lc_q;
    bad_a  = bad_q;
    ferr_a = ferr_q;
    sh_a   = sh_q;
    ph_a   = ph_q;
    dig_a  = dig_q;
    e_dot  = dnv_pkg::label_err(lc_q, sh_q, ph_q, cfg_i.min_label_length,
                                cfg_i.max_label_length);

    if (has_char_i) begin
      if (tot_q != TOT_SAT) begin
        tot_a = tot_q + TW'(1);
      end
      if (!dnv_pkg::is_allowed(char_byte_i)) begin
        bad_a = 1'b1;
      end
      if (char_byte_i == dnv_pkg::CH_DOT) begin
        if (ferr_q == dnv_pkg::LERR_NONE) begin
          ferr_a = e_dot;
        end
        lc_a  = 8'd0;
        sh_a  = 1'b0;
        ph_a  = 1'b0;
        dig_a = 1'b1;
      end else begin
        if (lc_q == 8'd0) begin
          sh_a = (char_byte_i == dnv_pkg::CH_HYPHEN);
        end
        if (lc_q != dnv_pkg::LABEL_CNT_SAT) begin
          lc_a = lc_q + 8'd1;
        end
        ph_a = (char_byte_i == dnv_pkg::CH_HYPHEN);
        if (!dnv_pkg::is_numeral(char_byte_i)) begin
          dig_a = 1'b0;
        end
      end
    end

    // close the top label at end of name
    e_end  = dnv_pkg::label_err(lc_a, sh_a, ph_a, cfg_i.min_label_length,
                                cfg_i.max_label_length);
    ferr_b = (ferr_a == dnv_pkg::LERR_NONE) ? e_end : ferr_a;
    tot_w  = CW'(tot_a);

    if (tot_a == '0) begin
      code_o = dnv_pkg::ST_EMPTY;
    end else if ((tot_w > CW'(cfg_i.max_name_length)) || (tot_w > MAX_BYTES_C)) begin
      code_o = dnv_pkg::ST_TOO_LONG;
    end else if (bad_a) begin
      code_o = dnv_pkg::ST_BAD_CHAR;
    end else begin
      case (ferr_b)
        dnv_pkg::LERR_SHORT:  code_o = dnv_pkg::ST_LABEL_SHORT;
        dnv_pkg::LERR_LONG:   code_o = dnv_pkg::ST_LABEL_LONG;
        dnv_pkg::LERR_HYPHEN: code_o = dnv_pkg::ST_HYPHEN_EDGE;
        default: begin
          code_o = (cfg_i.strict_top_label && dig_a) ? dnv_pkg::ST_NUMERIC_TOP
                                                     : dnv_pkg::ST_OK;
        end
      endcase
    end

    if (last_item_i) begin
      tot_d  = '0;
      lc_d   = 8'd0;
      bad_d  = 1'b0;
      ferr_d = dnv_pkg::LERR_NONE;
      sh_d   = 1'b0;
      ph_d   = 1'b0;
      dig_d  = 1'b1;
    end else begin
      tot_d  = tot_a;
      lc_d   = lc_a;
      bad_d  = bad_a;
      ferr_d = ferr_a;
      sh_d   = sh_a;
      ph_d   = ph_a;
      dig_d  = dig_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q  <= '0;
      lc_q   <= 8'd0;
      bad_q  <= 1'b0;
      ferr_q <= dnv_pkg::LERR_NONE;
      sh_q   <= 1'b0;
      ph_q   <= 1'b0;
      dig_q  <= 1'b1;
    end else if (step_i) begin
      tot_q  <= tot_d;
      lc_q   <= lc_d;
      bad_q  <= bad_d;
      ferr_q <= ferr_d;
      sh_q   <= sh_d;
      ph_q   <= ph_d;
      dig_q  <= dig_d;
    end
  end

  `DNV_ASSERT_SAME(a_tot_bound, 1'b1, tot_q <= TOT_SAT, "total count past saturation")
  `DNV_ASSERT_NEXT(a_name_cleared, step_i && last_item_i,
                   (tot_q == '0) && (lc_q == 8'd0) && (ferr_q == dnv_pkg::LERR_NONE),
                   "name state not cleared after last word")

endmodule

// ===== hdl/domain_name_validator_top.sv =====
// Host name validator.
// Input channel: one name byte per word (char_byte_i, has_char_i, last_item_i)
// with in_valid_i / in_stall_o. A word with has_char_i low adds nothing; with
// last_item_i high it ends the name, an empty one if no byte came before.
// Output channel: one status_code_o word per name, sent with out_valid_o /
// out_stall_i when the word flagged last_item_i has been processed.
// Path: an accepted word goes into the input register, then the scan logic
// writes the result register from it.
// Throughput: one word per cycle while the receiver does not stall; the
// per-byte update is a single pass of counters and flags.
// Limits and strict mode are set over the APB port (4 registers at 0x0, 0x4,
// 0x8, 0xC); write them only while no name is in flight.
// Reset clears the name state and loads the default limits.
// While the receiver stalls, the result is held; at most one more input word
// is taken into the input register, then in_stall_o rises until the result leaves.
`include "domain_name_validator_top_assert.svh"

module domain_name_validator_top #(
  parameter int MAX_NAME_BYTES = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        has_char_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_code_o
);

  dnv_pkg::cfg_t    cfg;
  dnv_pkg::status_e code;

  logic             in_valid_q, in_valid_d;
  logic [7:0]       char_q;
  logic             has_q, last_q;
  logic             out_valid_q, out_valid_d;
  dnv_pkg::status_e code_q;
  logic             in_acc, advance, step;

  assign advance    = !(out_valid_q && out_stall_i);
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (step && last_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q <= char_byte_i;
      has_q  <= has_char_i;
      last_q <= last_item_i;
    end
    if (step && last_q) begin
      code_q <= code;
    end
  end

  dnv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dnv_scan #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_byte_i (char_q),
    .has_char_i  (has_q),
    .last_item_i (last_q),
    .cfg_i       (cfg),
    .code_o      (code)
  );

  assign out_valid_o   = out_valid_q;
  assign status_code_o = code_q;

  `DNV_ASSERT_SAME(a_no_overrun, in_valid_q && !advance, !in_acc,
                   "input word taken over a pending word")
  `DNV_ASSERT_SAME(a_result_source, $rose(out_valid_q), $past(in_valid_q && last_q),
                   "result without a processed last word")

endmodule

// ===== test/dnv_checker.sv =====
`timescale 1ns / 1ps

module dnv_checker
  import dnv_pkg::*;
#(
  parameter int MAX_NAME_BYTES = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  char_byte_i,
  input  logic        has_char_i,
  input  logic        last_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_code_i,
  output int          fail_count_o,
  output int          pending_o
);

  cfg_t        cfg;
  int unsigned name_len;
  logic [7:0]  lbl_len;
  logic        bad_seen;
  logic        lbl_starts_hy;
  logic        last_was_hy;
  logic        lbl_digits;
  label_err_e  first_err;
  status_e     expected_codes[$];
  status_e     want_code;
  int          errors = 0;

  assign fail_count_o = errors;

  task automatic end_label();
    label_err_e err;
    err = LERR_NONE;
    if (lbl_len < 8'(cfg.min_label_length)) begin
      err = LERR_SHORT;
    end else if (lbl_len > 8'(cfg.max_label_length)) begin
      err = LERR_LONG;
    end else if ((lbl_len != 8'd0) && (lbl_starts_hy || last_was_hy)) begin
      err = LERR_HYPHEN;
    end
    // only the first label error of a name counts
    if (first_err == LERR_NONE) first_err = err;
    lbl_len       = 8'd0;
    lbl_starts_hy = 1'b0;
    last_was_hy   = 1'b0;
    lbl_digits    = 1'b1;
  endtask

  task automatic absorb_word(input logic [7:0] c, input logic has, input logic last);
    logic    digit;
    logic    top_digits;
    status_e code;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (has) begin
      if (name_len <= MAX_NAME_BYTES) name_len++;
      if (!(c inside {[CH_LOW_A:CH_LOW_Z], [CH_ZERO:CH_NINE], CH_HYPHEN, CH_DOT})) begin
        bad_seen = 1'b1;
      end
      if (c == CH_DOT) begin
        end_label();
      end else begin
        if (lbl_len == 8'd0) lbl_starts_hy = (c == CH_HYPHEN);
        if (lbl_len != LABEL_CNT_SAT) lbl_len++;
        last_was_hy = (c == CH_HYPHEN);
        if (!digit) lbl_digits = 1'b0;
      end
    end
    if (last) begin
      top_digits = lbl_digits;
      end_label();
      if (name_len == 0) begin
        code = ST_EMPTY;
      end else if ((name_len > cfg.max_name_length) || (name_len > MAX_NAME_BYTES)) begin
        code = ST_TOO_LONG;
      end else if (bad_seen) begin
        code = ST_BAD_CHAR;
      end else if (first_err != LERR_NONE) begin
        case (first_err)
          LERR_SHORT: code = ST_LABEL_SHORT;
          LERR_LONG:  code = ST_LABEL_LONG;
          default:    code = ST_HYPHEN_EDGE;
        endcase
      end else if (cfg.strict_top_label && top_digits) begin
        code = ST_NUMERIC_TOP;
      end else begin
        code = ST_OK;
      end
      expected_codes.push_back(code);
      name_len  = 0;
      bad_seen  = 1'b0;
      first_err = LERR_NONE;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.max_name_length  = RST_MAX_NAME;
      cfg.min_label_length = RST_MIN_LABEL;
      cfg.max_label_length = RST_MAX_LABEL;
      cfg.strict_top_label = RST_STRICT_TOP;
      name_len      = 0;
      lbl_len       = 8'd0;
      bad_seen      = 1'b0;
      lbl_starts_hy = 1'b0;
      last_was_hy   = 1'b0;
      lbl_digits    = 1'b1;
      first_err     = LERR_NONE;
      expected_codes.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_MAX_NAME:  cfg.max_name_length  = pwdata[7:0];
          REG_MIN_LABEL: cfg.min_label_length = pwdata[5:0];
          REG_MAX_LABEL: cfg.max_label_length = pwdata[5:0];
          default:       cfg.strict_top_label = pwdata[0];
        endcase
      end
      // retire the result first: a word accepted now cannot come out this cycle
      if (out_valid_i && !out_stall_i) begin
        if (expected_codes.size() == 0) begin
          errors++;
          $error("status_code: expected none, got %0d", status_code_i);
        end else begin
          want_code = expected_codes.pop_front();
          if (status_code_i !== want_code) begin
            errors++;
            $error("status_code: expected %0d, got %0d", want_code, status_code_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) absorb_word(char_byte_i, has_char_i, last_item_i);
      pending_o <= expected_codes.size();
    end
  end

endmodule

// ===== test/tb_domain_name_validator_top.sv =====
`timescale 1ns / 1ps

module tb_domain_name_validator_top;
  import dnv_pkg::*;

  localparam int NAME_BYTES  = 255;
  localparam int ITEM_GOAL   = 1050;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef enum {NAME_SHORT, NAME_LONG_DOTTED, NAME_LONG_LABEL} name_kind_e;
  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_byte_i = 8'd0;
  logic        has_char_i = 1'b0;
  logic        last_item_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_code_o;

  int fail_count;
  int names_pending;
  int cycle_count = 0;
  int burst_left = 0;
  int items_sent = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  domain_name_validator_top #(
    .MAX_NAME_BYTES(NAME_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_byte_i  (char_byte_i),
    .has_char_i   (has_char_i),
    .last_item_i  (last_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_code_o(status_code_o)
  );

  dnv_checker #(
    .MAX_NAME_BYTES(NAME_BYTES)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .char_byte_i  (char_byte_i),
    .has_char_i   (has_char_i),
    .last_item_i  (last_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_code_i(status_code_o),
    .fail_count_o (fail_count),
    .pending_o    (names_pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one word, opening a new burst after a random gap when the last one ran out.
  task automatic drive_word(input logic [7:0] c, input logic has, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    has_char_i  <= has;
    last_item_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (has || last) items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) drive_word(s[i], 1'b1, i == s.len() - 1);
  endtask

  task automatic send_name(input name_kind_e kind);
    logic [7:0]  name_q[$];
    logic [7:0]  c;
    int unsigned n_labels, lbl_len, r;
    bit          clean, digits, separate_end;
    if (kind == NAME_SHORT && $urandom_range(0, 99) < 3) begin
      drive_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    clean = 1'($urandom_range(0, 1));
    separate_end = $urandom_range(0, 99) < 12;
    case (kind)
      NAME_LONG_DOTTED: n_labels = $urandom_range(5, 6);
      NAME_LONG_LABEL:  n_labels = 1;
      default:          n_labels = $urandom_range(1, 4);
    endcase
    for (int i = 0; i < n_labels; i++) begin
      r = $urandom_range(0, 99);
      case (kind)
        NAME_LONG_DOTTED: lbl_len = $urandom_range(48, 60);
        NAME_LONG_LABEL:  lbl_len = $urandom_range(256, 270);
        default: begin
          lbl_len = (r < 4) ? 0 : (r < 80) ? $urandom_range(1, 8) :
                    (r < 95) ? $urandom_range(9, 20) : $urandom_range(60, 70);
        end
      endcase
      digits = (kind == NAME_SHORT) && ($urandom_range(0, 99) < 20);
      for (int j = 0; j < lbl_len; j++) begin
        r = $urandom_range(0, 99);
        if (digits) begin
          c = CH_ZERO + 8'($urandom_range(0, 9));
        end else if (clean) begin
          // keep hyphens off the label edges
          if (j > 0 && j + 1 < lbl_len && r < 10) c = CH_HYPHEN;
          else if (r < 75) c = CH_LOW_A + 8'($urandom_range(0, 25));
          else c = CH_ZERO + 8'($urandom_range(0, 9));
        end else begin
          if (r < 62) c = CH_LOW_A + 8'($urandom_range(0, 25));
          else if (r < 86) c = CH_ZERO + 8'($urandom_range(0, 9));
          else if (r < 92) c = CH_HYPHEN;
          else if (r < 96) c = CH_DOT;
          else if (r < 98) c = 8'h41 + 8'($urandom_range(0, 25));
          else c = 8'($urandom_range(0, 255));
        end
        name_q.push_back(c);
      end
      if (i != n_labels - 1 || $urandom_range(0, 99) < 5) name_q.push_back(CH_DOT);
    end
    foreach (name_q[k]) begin
      if ($urandom_range(0, 99) < 4) drive_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      drive_word(name_q[k], 1'b1, (k == name_q.size() - 1) && !separate_end);
    end
    if (separate_end || name_q.size() == 0) begin
      drive_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic wait_drained(input int unsigned settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (names_pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: stretches of random stall patterns, plus one long hold on request.
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(10, 100);
      for (int k = 0; k < span && !(hold_req && !hold_done); k++) begin
        @(posedge clk_i);
        case (mode)
          RX_FREE:  out_stall_i <= 1'b0;
          RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
          default:  out_stall_i <= k[1];
        endcase
      end
      if (hold_req && !hold_done) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
    end
  end

  initial begin
    int unsigned phase, phase_goal, r;
    logic [7:0]  mx_name;
    logic [5:0]  mn_lbl, mx_lbl;
    logic        strict;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed names under the reset limits
    drive_word(8'h00, 1'b0, 1'b1);
    send_text("a");
    send_text("-a");
    send_text("ab-");
    send_text("a.");
    send_text("42");
    send_text("a..b");
    send_text("A");
    drive_word(8'hFF, 1'b1, 1'b1);
    drive_word(8'h00, 1'b0, 1'b0);
    drive_word("z", 1'b1, 1'b0);
    drive_word(8'h5A, 1'b0, 1'b1);
    send_text("x-9.7");
    wait_drained(4);

    for (phase = 0; items_sent < ITEM_GOAL; phase++) begin
      case (phase)
        0: begin mx_name = 8'd255; mn_lbl = 6'd0;  mx_lbl = 6'd63; strict = 1'b1; end
        1: begin mx_name = 8'd1;   mn_lbl = 6'd0;  mx_lbl = 6'd1;  strict = 1'b0; end
        2: begin mx_name = 8'd40;  mn_lbl = 6'd63; mx_lbl = 6'd1;  strict = 1'b1; end
        3: begin mx_name = 8'd253; mn_lbl = 6'd1;  mx_lbl = 6'd63; strict = 1'b0; end
        default: begin
          r = $urandom_range(0, 3);
          mx_name = (r == 0) ? 8'($urandom_range(1, 255)) :
                    (r == 1) ? 8'($urandom_range(250, 255)) : 8'($urandom_range(8, 40));
          mn_lbl = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
                                                 6'($urandom_range(0, 3));
          mx_lbl = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(1, 63)) :
                                                 6'($urandom_range(4, 20));
          strict = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(REG_MAX_NAME, {24'd0, mx_name});
      write_reg(REG_MIN_LABEL, {26'd0, mn_lbl});
      write_reg(REG_MAX_LABEL, {26'd0, mx_lbl});
      write_reg(REG_STRICT_TOP, {31'd0, strict});
      if (phase == 1) hold_req = 1'b1;
      if (phase == 0) send_name(NAME_LONG_DOTTED);
      if (phase == 3) send_name(NAME_LONG_LABEL);
      phase_goal = items_sent + 120;
      while (items_sent < phase_goal && items_sent < ITEM_GOAL) send_name(NAME_SHORT);
      wait_drained(4);
    end

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
